// File: rtl/dtadv_pkg.sv
// Package for the date and time advance unit: sequencer states, register
// indexes, calendar constants and the month length table. No dependencies.
package dtadv_pkg;

    localparam int unsigned SecsPerDay = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin = 60;
    localparam int unsigned ExtraSecs = 2 * 60 * 60;
    localparam int unsigned YearMin = 2024;
    localparam int unsigned YearMax = 2099;
    localparam int unsigned CenturyBase = 2000;

    localparam int unsigned SecsW = 33;   // elapsed + extra + time of day
    localparam int unsigned RemW = 17;    // remainder below one day
    localparam int unsigned UnitW = 17;   // shared subtractor width
    localparam int unsigned DayW = 16;    // day count before month rollover
    localparam int unsigned CfgIdxW = 3;

    // One day is 675 * 2**7 seconds. The seconds are shifted right by 7 and the
    // quotient by 675 comes from a multiply by ceil(2**36 / 675), which is exact
    // for every shifted count below 2**26.
    localparam int unsigned DayShift = 7;
    localparam int unsigned DayOdd = 675;
    localparam int unsigned OddW = 10;                    // remainder below 675
    localparam int unsigned ScaledW = SecsW - DayShift;   // seconds over 128
    localparam int unsigned DayRecip = 101806633;
    localparam int unsigned RecipW = 27;
    localparam int unsigned RecipShift = 36;
    localparam int unsigned ProdW = ScaledW + RecipW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOD,
        ST_DIV,
        ST_REM,
        ST_HOUR,
        ST_MIN,
        ST_MONTH
    } t_state;

    typedef enum logic [CfgIdxW-1:0] {
        REG_YEAR   = 3'd0,
        REG_MONTH  = 3'd1,
        REG_DAY    = 3'd2,
        REG_HOUR   = 3'd3,
        REG_MINUTE = 3'd4,
        REG_SECOND = 3'd5
    } t_cfg_idx;

    // Length of month mon (1..12) in days, February extended in a leap year.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: rtl/date_time_advance_by_seconds_unit.sv
// Top level of the date and time advance unit: base registers, sequencer, a
// reciprocal multiply for the day split and one shared subtract/compare unit.
// Depends on dtadv_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------
//  clock     in         i_clk, i_rst_n (sync low) -
//  command   in         start, busy               i_elapsed_seconds, i_add_two_hours
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//  result    out        o_done (one-cycle strobe) o_valid_res, o_year_two_digit,
//                                                 o_month_out, o_day_out,
//                                                 o_hour_out, o_minute_out, o_second_out
//
// A command transfer happens at a rising edge with start high and busy low.
// With an out-of-range base, the zero result is strobed in the next cycle.
// Otherwise the item passes through ST_TOD, which adds the time of day, ST_DIV
// and ST_REM, which split the total into days and seconds of the day, ST_HOUR
// and ST_MIN, which count off hours and minutes, and ST_MONTH, which walks one
// month per step; the month walk through the single subtractor takes the
// longest. The result is strobed in the cycle busy falls. Reset returns the
// sequencer to idle and the base registers to 2024-01-01 00:00:00. The
// receiver cannot stall the result; configuration transfers are taken
// whenever the unit is not busy and start is low.
module date_time_advance_by_seconds_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   i_elapsed_seconds,
    input  logic                          i_add_two_hours,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dtadv_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [11:0]                   i_cfg_data,
    output logic                          o_done,
    output logic                          o_valid_res,
    output logic [6:0]                    o_year_two_digit,
    output logic [3:0]                    o_month_out,
    output logic [4:0]                    o_day_out,
    output logic [4:0]                    o_hour_out,
    output logic [5:0]                    o_minute_out,
    output logic [5:0]                    o_second_out
);
    import dtadv_pkg::*;

    // Base date and time registers.
    logic [11:0] r_base_year;
    logic [3:0]  r_base_month;
    logic [4:0]  r_base_day;
    logic [4:0]  r_base_hour;
    logic [5:0]  r_base_minute;
    logic [5:0]  r_base_second;

    // Sequencer and working registers.
    t_state              r_state, n_state;
    logic [SecsW-1:0]    r_num, n_num;     // total seconds
    logic [RemW-1:0]     r_rem, n_rem;     // seconds within the day
    logic [DayW-1:0]     r_day, n_day;
    logic [3:0]          r_mon, n_mon;
    logic [6:0]          r_yy, n_yy;       // year modulo 100
    logic [1:0]          r_cent, n_cent;   // century modulo 4, for the 400-year rule
    logic [4:0]          r_hour, n_hour;
    logic [5:0]          r_min, n_min;

    // Result registers.
    logic                r_done, n_done;
    logic                r_valid, n_valid;
    logic [6:0]          r_o_yy, n_o_yy;
    logic [3:0]          r_o_mon, n_o_mon;
    logic [4:0]          r_o_day, n_o_day;
    logic [4:0]          r_o_hour, n_o_hour;
    logic [5:0]          r_o_min, n_o_min;
    logic [5:0]          r_o_sec, n_o_sec;

    logic                base_ok;
    logic                accept;
    logic [RemW-1:0]     tod_secs;
    logic                leap;
    logic [4:0]          mon_len;

    // Day split: total seconds over 128, its quotient by 675 and the remainder.
    logic [ScaledW-1:0]  scaled;
    logic [ProdW-1:0]    recip_prod;
    logic [ScaledW-1:0]  odd_rem;

    // Shared subtract/compare unit.
    logic [UnitW-1:0]    u_a, u_b, u_diff;
    logic                u_ge;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = ~busy & ~start;
    assign accept      = start & ~busy;

    assign base_ok = (r_base_day >= 5'd1) &&
                     (r_base_year >= 12'(YearMin)) && (r_base_year <= 12'(YearMax)) &&
                     (r_base_month >= 4'd1) && (r_base_month <= 4'd12) &&
                     (r_base_hour <= 5'd23) && (r_base_minute <= 6'd59) &&
                     (r_base_second <= 6'd59);

    // Time of day of the base in seconds; only used once the base is known valid.
    assign tod_secs = RemW'(r_base_hour) * RemW'(SecsPerHour) +
                      RemW'(r_base_minute) * RemW'(SecsPerMin) +
                      RemW'(r_base_second);

    // The quotient lands in r_day during ST_DIV; ST_REM reads it back for the
    // remainder, which is below 675 and so fits the low bits of odd_rem.
    assign scaled     = r_num[SecsW-1:DayShift];
    assign recip_prod = ProdW'(scaled) * ProdW'(DayRecip);
    assign odd_rem    = scaled - ScaledW'(r_day) * ScaledW'(DayOdd);

    // A year is leap when divisible by 4, except century years whose
    // century count is not a multiple of four.
    assign leap    = (r_yy[1:0] == 2'd0) && ((r_yy != 7'd0) || (r_cent == 2'd0));
    assign mon_len = month_len(r_mon, leap);

    always_comb begin
        case (r_state)
            ST_HOUR:  begin
                u_a = UnitW'(r_rem);
                u_b = UnitW'(SecsPerHour);
            end
            ST_MIN:   begin
                u_a = UnitW'(r_rem);
                u_b = UnitW'(SecsPerMin);
            end
            ST_MONTH: begin
                u_a = UnitW'(r_day);
                u_b = UnitW'(mon_len);
            end
            default:  begin
                u_a = '0;
                u_b = '0;
            end
        endcase
        u_diff = u_a - u_b;
        u_ge   = (u_a >= u_b);
    end

    // Next state and working values.
    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_rem   = r_rem;
        n_day   = r_day;
        n_mon   = r_mon;
        n_yy    = r_yy;
        n_cent  = r_cent;
        n_hour  = r_hour;
        n_min   = r_min;
        n_done  = 1'b0;
        n_valid = r_valid;
        n_o_yy  = r_o_yy;
        n_o_mon = r_o_mon;
        n_o_day = r_o_day;
        n_o_hour = r_o_hour;
        n_o_min = r_o_min;
        n_o_sec = r_o_sec;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (base_ok) begin
                        n_num   = {1'b0, i_elapsed_seconds} +
                                  (i_add_two_hours ? SecsW'(ExtraSecs) : '0);
                        n_rem   = '0;
                        n_hour  = '0;
                        n_min   = '0;
                        n_mon   = r_base_month;
                        n_yy    = 7'(r_base_year - 12'(CenturyBase));
                        n_cent  = 2'd0;
                        n_state = ST_TOD;
                    end else begin
                        // Out-of-range base: every field reads zero.
                        n_done   = 1'b1;
                        n_valid  = 1'b0;
                        n_o_yy   = '0;
                        n_o_mon  = '0;
                        n_o_day  = '0;
                        n_o_hour = '0;
                        n_o_min  = '0;
                        n_o_sec  = '0;
                    end
                end
            end
            ST_TOD: begin
                n_num   = r_num + SecsW'(tod_secs);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // Whole days elapsed, from the reciprocal product.
                n_day   = recip_prod[RecipShift +: DayW];
                n_state = ST_REM;
            end
            ST_REM: begin
                // Seconds within the day, then the base day is added on.
                n_rem   = {odd_rem[OddW-1:0], r_num[DayShift-1:0]};
                n_day   = r_day + DayW'(r_base_day);
                n_state = ST_HOUR;
            end
            ST_HOUR: begin
                if (u_ge) begin
                    n_rem  = u_diff[RemW-1:0];
                    n_hour = r_hour + 5'd1;
                end else begin
                    n_state = ST_MIN;
                end
            end
            ST_MIN: begin
                if (u_ge) begin
                    n_rem = u_diff[RemW-1:0];
                    n_min = r_min + 6'd1;
                end else begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (u_ge && (u_diff != '0)) begin
                    // Day lies past this month: step into the next one.
                    n_day = u_diff[DayW-1:0];
                    if (r_mon == 4'd12) begin
                        n_mon = 4'd1;
                        if (r_yy == 7'd99) begin
                            n_yy   = 7'd0;
                            n_cent = r_cent + 2'd1;
                        end else begin
                            n_yy = r_yy + 7'd1;
                        end
                    end else begin
                        n_mon = r_mon + 4'd1;
                    end
                end else begin
                    n_done   = 1'b1;
                    n_valid  = 1'b1;
                    n_o_yy   = r_yy;
                    n_o_mon  = r_mon;
                    n_o_day  = r_day[4:0];
                    n_o_hour = r_hour;
                    n_o_min  = r_min;
                    n_o_sec  = r_rem[5:0];
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_day    <= n_day;
        r_mon    <= n_mon;
        r_yy     <= n_yy;
        r_cent   <= n_cent;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_valid  <= n_valid;
        r_o_yy   <= n_o_yy;
        r_o_mon  <= n_o_mon;
        r_o_day  <= n_o_day;
        r_o_hour <= n_o_hour;
        r_o_min  <= n_o_min;
        r_o_sec  <= n_o_sec;
    end

    // Base registers, written through the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_year   <= 12'(YearMin);
            r_base_month  <= 4'd1;
            r_base_day    <= 5'd1;
            r_base_hour   <= '0;
            r_base_minute <= '0;
            r_base_second <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_YEAR:   r_base_year   <= i_cfg_data;
                REG_MONTH:  r_base_month  <= i_cfg_data[3:0];
                REG_DAY:    r_base_day    <= i_cfg_data[4:0];
                REG_HOUR:   r_base_hour   <= i_cfg_data[4:0];
                REG_MINUTE: r_base_minute <= i_cfg_data[5:0];
                REG_SECOND: r_base_second <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign o_done           = r_done;
    assign o_valid_res      = r_valid;
    assign o_year_two_digit = r_o_yy;
    assign o_month_out      = r_o_mon;
    assign o_day_out        = r_o_day;
    assign o_hour_out       = r_o_hour;
    assign o_minute_out     = r_o_min;
    assign o_second_out     = r_o_sec;

`ifndef SYNTH
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while the sequencer is still busy");

    a_valid_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && base_ok) |=> (busy && !o_done))
        else $error("valid command did not start the sequencer");

    a_bad_base : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !base_ok) |=> (o_done && !o_valid_res))
        else $error("out-of-range base did not give an immediate invalid result");

    a_result_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_valid_res) |-> ((o_month_out >= 4'd1) && (o_month_out <= 4'd12) &&
        (o_day_out >= 5'd1) && (o_hour_out <= 5'd23) && (o_minute_out <= 6'd59) &&
        (o_second_out <= 6'd59) && (o_year_two_digit <= 7'd99)))
        else $error("valid result holds an out-of-range field");

    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> ((o_year_two_digit == '0) && (o_month_out == '0) &&
        (o_day_out == '0) && (o_hour_out == '0) && (o_minute_out == '0) &&
        (o_second_out == '0)))
        else $error("invalid result carries nonzero fields");
`endif

endmodule
